>>> rtl/core/wfpa_pkg.sv
package wfpa_pkg;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_COMMIT
  } state_t;

  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_ALLOC = 1'b1;

  typedef struct packed {
    logic clr;
    logic en;
  } best_ctl_t;

endpackage

>>> rtl/core/wfpa_ram.sv
module wfpa_ram #(
  parameter int WIDTH = 17,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> rtl/core/wfpa_best.sv
module wfpa_best #(
  parameter int SIZE_BITS = 16,
  parameter int AW        = 6,
  parameter int CW        = 16
) (
  input  logic                 clk,
  input  wfpa_pkg::best_ctl_t  ctl,
  input  logic                 ent_busy,
  input  logic [SIZE_BITS-1:0] ent_size,
  input  logic [AW-1:0]        ent_idx,
  input  logic [15:0]          need,
  output logic                 found,
  output logic [AW-1:0]        best_idx,
  output logic [CW-1:0]        best_left,
  output logic [SIZE_BITS-1:0] best_size
);

  logic                 found_r, found_nxt;
  logic [AW-1:0]        idx_r, idx_nxt;
  logic [CW-1:0]        left_r, left_nxt;
  logic [SIZE_BITS-1:0] size_r, size_nxt;
  logic [CW-1:0]        sz_ext, need_ext, left;
  logic                 take;

  assign sz_ext   = CW'(ent_size);
  assign need_ext = CW'(need);
  assign left     = sz_ext - need_ext;
  assign take     = !ent_busy && (sz_ext >= need_ext) && (!found_r || (left > left_r));

  always_comb begin
    found_nxt = found_r;
    idx_nxt   = idx_r;
    left_nxt  = left_r;
    size_nxt  = size_r;
    if (ctl.clr) begin
      found_nxt = 1'b0;
      idx_nxt   = '0;
      left_nxt  = '0;
    end else if (ctl.en && take) begin
      found_nxt = 1'b1;
      idx_nxt   = ent_idx;
      left_nxt  = left;
      size_nxt  = ent_size;
    end
  end

  always_ff @(posedge clk) begin
    found_r <= found_nxt;
    idx_r   <= idx_nxt;
    left_r  <= left_nxt;
    size_r  <= size_nxt;
  end

  assign found     = found_r;
  assign best_idx  = idx_r;
  assign best_left = left_r;
  assign best_size = size_r;

endmodule

>>> rtl/core/worst_fit_partition_allocator_top.sv
// Load transaction: busy stays low, no result.
// Allocate transaction: scans N = min(partitions_in_use, PARTITIONS) entries,
// one partition-table read and one leftover compare per cycle; the result
// strobe follows COMMIT (after DRAIN, or IDLE if N is 0); busy low with it.
// Synchronous active-low reset: idle, partitions_in_use 0; table not cleared.
// Results are strobed for one cycle; the receiver cannot stall.
module worst_fit_partition_allocator_top #(
  parameter int PARTITIONS = 64,
  parameter int SIZE_BITS  = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_action,
  input  logic [5:0]  in_slot,
  input  logic [15:0] in_slot_size,
  input  logic [15:0] in_job_tag,
  input  logic [15:0] in_job_need,
  input  logic        cfg_we,
  input  logic [6:0]  cfg_wdata,
  output logic        out_strobe,
  output logic [15:0] out_job,
  output logic        out_granted,
  output logic [5:0]  out_chosen_slot,
  output logic [15:0] out_leftover
);

  localparam int AW   = $clog2(PARTITIONS);
  localparam int CNTW = $clog2(PARTITIONS + 1);
  localparam int CW   = (SIZE_BITS > 16) ? SIZE_BITS : 16;
  localparam int RW   = SIZE_BITS + 1;

  wfpa_pkg::state_t state_r, state_nxt;

  logic [6:0]      cfg_r;
  logic [CNTW-1:0] cnt_r, cnt_nxt, cnt_sat;
  logic [AW-1:0]   idx_r, idx_nxt;
  logic [15:0]     tag_r, tag_nxt;
  logic [15:0]     need_r, need_nxt;
  logic            dv_r;
  logic [AW-1:0]   pidx_r;

  logic            accept, last_issue, slot_ok;

  logic            ram_we, ram_re;
  logic [AW-1:0]   ram_waddr;
  logic [RW-1:0]   ram_wdata, ram_rdata;

  wfpa_pkg::best_ctl_t  best_ctl;
  logic                 best_found;
  logic [AW-1:0]        best_idx;
  logic [CW-1:0]        best_left;
  logic [SIZE_BITS-1:0] best_size;

  logic        out_strobe_r;
  logic [15:0] out_job_r;
  logic        out_granted_r;
  logic [5:0]  out_slot_r;
  logic [15:0] out_left_r;

  assign busy       = (state_r != wfpa_pkg::ST_IDLE);
  assign accept     = start && !busy;
  assign slot_ok    = (32'(in_slot) < PARTITIONS);
  assign cnt_sat    = (32'(cfg_r) > PARTITIONS) ? CNTW'(PARTITIONS) : CNTW'(cfg_r);
  assign last_issue = ((32'(idx_r) + 32'd1) == 32'(cnt_r));

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      wfpa_pkg::ST_IDLE: begin
        if (accept && (in_action == wfpa_pkg::ACT_ALLOC)) begin
          state_nxt = (cnt_sat == '0) ? wfpa_pkg::ST_COMMIT : wfpa_pkg::ST_SCAN;
        end
      end
      wfpa_pkg::ST_SCAN: begin
        if (last_issue) begin
          state_nxt = wfpa_pkg::ST_DRAIN;
        end
      end
      wfpa_pkg::ST_DRAIN:  state_nxt = wfpa_pkg::ST_COMMIT;
      wfpa_pkg::ST_COMMIT: state_nxt = wfpa_pkg::ST_IDLE;
      default:             state_nxt = wfpa_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ram_we       = 1'b0;
    ram_waddr    = AW'(in_slot);
    ram_wdata    = {1'b0, SIZE_BITS'(in_slot_size)};
    ram_re       = 1'b0;
    best_ctl.clr = 1'b0;
    best_ctl.en  = dv_r;
    idx_nxt      = idx_r;
    cnt_nxt      = cnt_r;
    tag_nxt      = tag_r;
    need_nxt     = need_r;
    case (state_r)
      wfpa_pkg::ST_IDLE: begin
        if (accept) begin
          if (in_action == wfpa_pkg::ACT_LOAD) begin
            ram_we = slot_ok;
          end else begin
            best_ctl.clr = 1'b1;
            idx_nxt      = '0;
            cnt_nxt      = cnt_sat;
            tag_nxt      = in_job_tag;
            need_nxt     = in_job_need;
          end
        end
      end
      wfpa_pkg::ST_SCAN: begin
        ram_re  = 1'b1;
        idx_nxt = idx_r + AW'(1);
      end
      wfpa_pkg::ST_COMMIT: begin
        ram_we    = best_found;
        ram_waddr = best_idx;
        ram_wdata = {1'b1, best_size};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= wfpa_pkg::ST_IDLE;
      cfg_r        <= '0;
      dv_r         <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      dv_r         <= ram_re;
      out_strobe_r <= (state_r == wfpa_pkg::ST_COMMIT);
      if (cfg_we) begin
        cfg_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r  <= idx_nxt;
    cnt_r  <= cnt_nxt;
    tag_r  <= tag_nxt;
    need_r <= need_nxt;
    pidx_r <= idx_r;
    if (state_r == wfpa_pkg::ST_COMMIT) begin
      out_job_r     <= tag_r;
      out_granted_r <= best_found;
      out_slot_r    <= best_found ? 6'(best_idx) : 6'd0;
      out_left_r    <= best_found ? 16'(best_left) : 16'd0;
    end
  end

  wfpa_ram #(
    .WIDTH(RW),
    .DEPTH(PARTITIONS)
  ) u_ram (
    .clk    (clk),
    .wr_en  (ram_we),
    .wr_addr(ram_waddr),
    .wr_data(ram_wdata),
    .rd_en  (ram_re),
    .rd_addr(idx_r),
    .rd_data(ram_rdata)
  );

  wfpa_best #(
    .SIZE_BITS(SIZE_BITS),
    .AW       (AW),
    .CW       (CW)
  ) u_best (
    .clk      (clk),
    .ctl      (best_ctl),
    .ent_busy (ram_rdata[RW-1]),
    .ent_size (ram_rdata[SIZE_BITS-1:0]),
    .ent_idx  (pidx_r),
    .need     (need_r),
    .found    (best_found),
    .best_idx (best_idx),
    .best_left(best_left),
    .best_size(best_size)
  );

  assign out_strobe      = out_strobe_r;
  assign out_job         = out_job_r;
  assign out_granted     = out_granted_r;
  assign out_chosen_slot = out_slot_r;
  assign out_leftover    = out_left_r;

endmodule
